// File: rtl/core/dkam_pkg.sv
// Shared types and constants for the dual key address map.
// No dependencies; imported by every module of the block.
package dkam_pkg;

  // default table depth
  localparam int DKAM_ENTRIES = 16;

  localparam int SHORT_W = 16;
  localparam int LONG_W  = 64;
  localparam int CAP_W   = 8;
  localparam int OP_W    = 3;
  localparam int STAT_W  = 2;
  localparam int CFG_INDEX_W = 2;

  // capability value that leaves the stored byte alone
  localparam logic [CAP_W-1:0] CAP_KEEP = 8'hff;

  typedef enum logic [OP_W-1:0] {
    OP_ADD         = 3'd0,
    OP_REMOVE_SHORT = 3'd1,
    OP_REMOVE_LONG = 3'd2,
    OP_GET_SHORT   = 3'd3,
    OP_GET_LONG    = 3'd4,
    OP_CLEAR       = 3'd5
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STATUS_OK   = 2'd0,
    STATUS_MISS = 2'd1,
    STATUS_FULL = 2'd2
  } status_t;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_INVALID_SHORT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_INVALID_LONG  = 2'd1;

  // one operation handed to the table
  typedef struct packed {
    logic               go;
    logic [OP_W-1:0]    op;
    logic [SHORT_W-1:0] short_key;
    logic [LONG_W-1:0]  long_key;
    logic [CAP_W-1:0]   capability;
  } cmd_t;

  // result of one operation
  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [SHORT_W-1:0] short_out;
    logic [LONG_W-1:0]  long_out;
    logic [CAP_W-1:0]   capability_out;
  } rsp_t;

endpackage

// File: rtl/core/dkam_cfg.sv
// Configuration registers: the miss values returned on lookups.
// Depends on dkam_pkg.
module dkam_cfg import dkam_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  logic [CFG_INDEX_W-1:0] wr_index,
  input  logic [LONG_W-1:0]      wr_data,
  output logic [SHORT_W-1:0]     invalid_short,
  output logic [LONG_W-1:0]      invalid_long
);

  // register writes, unknown indexes dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      invalid_short <= '1;
      invalid_long  <= '1;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_INVALID_SHORT: invalid_short <= wr_data[SHORT_W-1:0];
        REG_INVALID_LONG:  invalid_long  <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/core/dkam_table.sv
// Slot storage with parallel match on both keys, lowest-slot priority,
// readout and update. Depends on dkam_pkg.
module dkam_table import dkam_pkg::*; #(
  parameter int ENTRIES = DKAM_ENTRIES
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  input  logic [SHORT_W-1:0] invalid_short,
  input  logic [LONG_W-1:0]  invalid_long,
  output rsp_t               rsp
);

  localparam logic [ENTRIES-1:0] ONE = ENTRIES'(1);

  logic [ENTRIES-1:0] slot_valid;
  logic [SHORT_W-1:0] slot_short [ENTRIES];
  logic [LONG_W-1:0]  slot_long [ENTRIES];
  logic [CAP_W-1:0]   slot_capability [ENTRIES];

  logic [ENTRIES-1:0] hit_short, hit_long, slot_free;
  logic [ENTRIES-1:0] first_short, first_long, first_free;
  logic [ENTRIES-1:0] add_sel, remove_sel, read_sel;
  logic               add_new, add_full;
  logic [SHORT_W-1:0] rd_short;
  logic [LONG_W-1:0]  rd_long;
  logic [CAP_W-1:0]   rd_cap;
  logic               do_add, do_clear;
  op_t                op;

  assign op = op_t'(cmd.op);

  // compare every slot against both keys
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      hit_short[i] = slot_valid[i] && (slot_short[i] == cmd.short_key);
      hit_long[i]  = slot_valid[i] && (slot_long[i] == cmd.long_key);
    end
  end
  assign slot_free = ~slot_valid;

  // isolate the lowest set bit of each vector
  assign first_short = hit_short & (~hit_short + ONE);
  assign first_long  = hit_long & (~hit_long + ONE);
  assign first_free  = slot_free & (~slot_free + ONE);

  // add target: short match, then long match, then lowest free slot
  assign add_new  = (hit_short == '0) && (hit_long == '0);
  assign add_full = add_new && (slot_free == '0);
  assign add_sel  = (hit_short != '0) ? first_short :
                    (hit_long != '0)  ? first_long : first_free;

  assign remove_sel = (op == OP_REMOVE_SHORT) ? first_short : first_long;
  assign read_sel   = (op == OP_GET_LONG) ? first_short : first_long;

  // one-hot readout of the hit slot
  always_comb begin
    rd_short = '0;
    rd_long  = '0;
    rd_cap   = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      rd_short = rd_short | ({SHORT_W{read_sel[i]}} & slot_short[i]);
      rd_long  = rd_long | ({LONG_W{read_sel[i]}} & slot_long[i]);
      rd_cap   = rd_cap | ({CAP_W{read_sel[i]}} & slot_capability[i]);
    end
  end

  // result of the operation
  always_comb begin
    rsp.status         = STATUS_OK;
    rsp.short_out      = invalid_short;
    rsp.long_out       = invalid_long;
    rsp.capability_out = '0;
    unique case (op)
      OP_ADD: begin
        if (add_full) rsp.status = STATUS_FULL;
      end
      OP_REMOVE_SHORT: begin
        if (hit_short == '0) rsp.status = STATUS_MISS;
      end
      OP_REMOVE_LONG: begin
        if (hit_long == '0) rsp.status = STATUS_MISS;
      end
      OP_GET_SHORT: begin
        if (hit_long == '0) begin
          rsp.status = STATUS_MISS;
        end else begin
          rsp.short_out      = rd_short;
          rsp.capability_out = rd_cap;
        end
      end
      OP_GET_LONG: begin
        if (hit_short == '0) begin
          rsp.status = STATUS_MISS;
        end else begin
          rsp.long_out       = rd_long;
          rsp.capability_out = rd_cap;
        end
      end
      OP_CLEAR: ;
      default: rsp.status = STATUS_MISS;
    endcase
  end

  assign do_add   = cmd.go && (op == OP_ADD) && !add_full;
  assign do_clear = cmd.go && (op == OP_CLEAR);

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (do_clear) begin
      slot_valid <= '0;
    end else if (do_add) begin
      slot_valid <= slot_valid | add_sel;
    end else if (cmd.go && (op == OP_REMOVE_SHORT || op == OP_REMOVE_LONG)) begin
      slot_valid <= slot_valid & ~remove_sel;
    end
  end

  // slot payload written on add
  always_ff @(posedge clk) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (do_add && add_sel[i]) begin
        slot_short[i] <= cmd.short_key;
        slot_long[i]  <= cmd.long_key;
        if (cmd.capability != CAP_KEEP) begin
          slot_capability[i] <= cmd.capability;
        end else if (add_new) begin
          slot_capability[i] <= '0;
        end
      end
    end
  end

endmodule

// File: rtl/core/dual_key_address_map_unit.sv
// Top level of the dual key address map: input and result registers
// around the slot table. Depends on dkam_pkg, dkam_cfg and dkam_table.

// The block takes one operation per clock while the output is not stalled and
// returns one result per operation, through an input register and a result
// register. Each operation is settled in a single pass: every slot is compared
// against both keys at once and a lowest-slot priority encoder picks the
// winner, so the table update is in place before the next operation reads it.
// The configuration port is always ready; write it only while the block is
// idle. Slots start empty after reset, with no clearing pass.
module dual_key_address_map_unit import dkam_pkg::*; #(
  parameter int ENTRIES = DKAM_ENTRIES
) (
  input  logic                   clk,
  input  logic                   rst,
  // input channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [OP_W-1:0]        op,
  input  logic [SHORT_W-1:0]     short_key,
  input  logic [LONG_W-1:0]      long_key,
  input  logic [CAP_W-1:0]       capability,
  // result channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [STAT_W-1:0]      status,
  output logic [SHORT_W-1:0]     short_out,
  output logic [LONG_W-1:0]      long_out,
  output logic [CAP_W-1:0]       capability_out,
  // configuration channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [LONG_W-1:0]      cfg_data
);

  logic               in_full;
  cmd_t               in_reg;
  logic               advance;
  cmd_t               cmd;
  rsp_t               rsp;
  logic [SHORT_W-1:0] invalid_short;
  logic [LONG_W-1:0]  invalid_long;

  assign cfg_ready = 1'b1;

  // an operation moves on when the result register is free or draining
  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_reg.go         <= 1'b1;
      in_reg.op         <= op;
      in_reg.short_key  <= short_key;
      in_reg.long_key   <= long_key;
      in_reg.capability <= capability;
    end
  end

  always_comb begin
    cmd    = in_reg;
    cmd.go = advance;
  end

  dkam_cfg u_cfg (
    .clk           (clk),
    .rst           (rst),
    .wr_en         (cfg_valid && cfg_ready),
    .wr_index      (cfg_index),
    .wr_data       (cfg_data),
    .invalid_short (invalid_short),
    .invalid_long  (invalid_long)
  );

  dkam_table #(
    .ENTRIES (ENTRIES)
  ) u_table (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .invalid_short (invalid_short),
    .invalid_long  (invalid_long),
    .rsp           (rsp)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      status         <= rsp.status;
      short_out      <= rsp.short_out;
      long_out       <= rsp.long_out;
      capability_out <= rsp.capability_out;
    end
  end

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for dual_key_address_map_unit: random and directed
// table operations checked against an in-bench model of the slot table.
// Depends on dkam_pkg and the dual_key_address_map_unit RTL.
module testbench import dkam_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_PCT     = 37;
  localparam int HOLD_CYCLES  = 120;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 4;

  // op codes with no operation behind them
  localparam logic [OP_W-1:0] OP_RESERVED_A = 3'd6;
  localparam logic [OP_W-1:0] OP_RESERVED_B = 3'd7;

  // register indexes past the end of the register list
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

  typedef struct {
    logic [OP_W-1:0]    op;
    logic [SHORT_W-1:0] short_key;
    logic [LONG_W-1:0]  long_key;
    logic [CAP_W-1:0]   capability;
  } map_op_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [OP_W-1:0]        op = '0;
  logic [SHORT_W-1:0]     short_key = '0;
  logic [LONG_W-1:0]      long_key = '0;
  logic [CAP_W-1:0]       capability = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [STAT_W-1:0]      status;
  logic [SHORT_W-1:0]     short_out;
  logic [LONG_W-1:0]      long_out;
  logic [CAP_W-1:0]       capability_out;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [LONG_W-1:0]      cfg_data = '0;

  // model of the slot table and its registers
  bit                 map_valid [DKAM_ENTRIES];
  logic [SHORT_W-1:0] map_short [DKAM_ENTRIES];
  logic [LONG_W-1:0]  map_long [DKAM_ENTRIES];
  logic [CAP_W-1:0]   map_cap [DKAM_ENTRIES];
  logic [SHORT_W-1:0] inv_short = '1;
  logic [LONG_W-1:0]  inv_long = '1;

  map_op_t ops_to_send[$];
  rsp_t    map_replies[$];
  map_op_t sent_op;

  bit calm = 1'b0;
  int holds_asked = 0;
  int holds_served = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int failures = 0;
  int results_checked = 0;
  int reg_writes = 0;
  int status_seen [4];

  dual_key_address_map_unit dut (.*);

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // lowest valid slot holding this short address, -1 if none
  function automatic int find_short(logic [SHORT_W-1:0] key);
    for (int i = 0; i < DKAM_ENTRIES; i++)
      if (map_valid[i] && map_short[i] == key) return i;
    return -1;
  endfunction

  // lowest valid slot holding this extended address, -1 if none
  function automatic int find_long(logic [LONG_W-1:0] key);
    for (int i = 0; i < DKAM_ENTRIES; i++)
      if (map_valid[i] && map_long[i] == key) return i;
    return -1;
  endfunction

  // apply one operation to the table model and return its result
  function automatic rsp_t map_apply(map_op_t it);
    rsp_t r;
    int   s;
    r.status         = STATUS_OK;
    r.short_out      = inv_short;
    r.long_out       = inv_long;
    r.capability_out = '0;
    case (it.op)
      OP_ADD: begin
        s = find_short(it.short_key);
        if (s < 0) s = find_long(it.long_key);
        if (s < 0) begin
          for (int i = DKAM_ENTRIES - 1; i >= 0; i--)
            if (!map_valid[i]) s = i;
          if (s >= 0) begin
            map_valid[s] = 1'b1;
            map_cap[s]   = '0;
          end
        end
        if (s < 0) begin
          r.status = STATUS_FULL;
        end else begin
          map_short[s] = it.short_key;
          map_long[s]  = it.long_key;
          if (it.capability != CAP_KEEP) map_cap[s] = it.capability;
        end
      end
      OP_REMOVE_SHORT, OP_REMOVE_LONG: begin
        s = (it.op == OP_REMOVE_SHORT) ? find_short(it.short_key) : find_long(it.long_key);
        if (s < 0) r.status = STATUS_MISS;
        else map_valid[s] = 1'b0;
      end
      OP_GET_SHORT: begin
        s = find_long(it.long_key);
        if (s < 0) begin
          r.status = STATUS_MISS;
        end else begin
          r.short_out      = map_short[s];
          r.capability_out = map_cap[s];
        end
      end
      OP_GET_LONG: begin
        s = find_short(it.short_key);
        if (s < 0) begin
          r.status = STATUS_MISS;
        end else begin
          r.long_out       = map_long[s];
          r.capability_out = map_cap[s];
        end
      end
      OP_CLEAR: begin
        foreach (map_valid[i]) map_valid[i] = 1'b0;
      end
      default: begin
        r.status = STATUS_MISS;
      end
    endcase
    status_seen[r.status]++;
    return r;
  endfunction

  // input driver: predict on each transfer, then present the next pending op
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) map_replies.push_back(map_apply(sent_op));
      if (!in_valid || !in_stall) begin
        if (ops_to_send.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          sent_op    = ops_to_send.pop_front();
          in_valid   <= 1'b1;
          op         <= sent_op.op;
          short_key  <= sent_op.short_key;
          long_key   <= sent_op.long_key;
          capability <= sent_op.capability;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor: check each transfer, drive random and long stalls
  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_checked++;
        if (map_replies.size() == 0) begin
          $error("result transfer with no operation outstanding");
          failures++;
        end else begin
          want = map_replies.pop_front();
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            failures++;
          end
          if (short_out !== want.short_out) begin
            $error("short_out: expected %h, got %h", want.short_out, short_out);
            failures++;
          end
          if (long_out !== want.long_out) begin
            $error("long_out: expected %h, got %h", want.long_out, long_out);
            failures++;
          end
          if (capability_out !== want.capability_out) begin
            $error("capability_out: expected %h, got %h", want.capability_out,
                   capability_out);
            failures++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (holds_served < holds_asked) begin
        holds_served++;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  // watchdog on cycles with no transfer anywhere
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout after %0d cycles without a transfer", quiet_cycles);
      $display("dual_key_address_map_unit regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_op(logic [OP_W-1:0] code, logic [SHORT_W-1:0] skey,
                          logic [LONG_W-1:0] lkey, logic [CAP_W-1:0] cap);
    map_op_t it;
    it.op         = code;
    it.short_key  = skey;
    it.long_key   = lkey;
    it.capability = cap;
    ops_to_send.push_back(it);
  endtask

  // wait until every op is sent and every result is back, then let the pipe drain
  task automatic wait_idle();
    do @(negedge clk);
    while (ops_to_send.size() != 0 || in_valid || map_replies.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // one register write transfer, mirrored into the model
  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [LONG_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_INVALID_SHORT: inv_short = data[SHORT_W-1:0];
      REG_INVALID_LONG:  inv_long = data;
      default: ;
    endcase
    reg_writes++;
  endtask

  // random ops over a pool of address pairs, with some noise keys
  task automatic run_phase(int pool_n, int n_items, bit long_hold);
    logic [SHORT_W-1:0] pool_short [32];
    logic [LONG_W-1:0]  pool_long [32];
    map_op_t            it;
    int                 pick;
    int                 k;
    for (int i = 0; i < pool_n; i++) begin
      pool_short[i] = SHORT_W'($urandom);
      pool_long[i]  = {$urandom, $urandom};
    end
    repeat (n_items) begin
      pick          = $urandom_range(0, 99);
      k             = $urandom_range(0, pool_n - 1);
      it.short_key  = pool_short[k];
      it.long_key   = pool_long[k];
      it.capability = ($urandom_range(0, 4) == 0) ? CAP_KEEP : CAP_W'($urandom_range(0, 255));
      if ($urandom_range(0, 99) < 15) begin
        it.short_key = SHORT_W'($urandom);
        it.long_key  = {$urandom, $urandom};
      end
      if (pick < 34 || pick >= 94) begin
        it.op = OP_ADD;
        // mixed pair so short and long matches land on different slots
        if ($urandom_range(0, 99) < 15) it.long_key = pool_long[$urandom_range(0, pool_n - 1)];
      end else if (pick < 44) begin
        it.op = OP_REMOVE_SHORT;
      end else if (pick < 54) begin
        it.op = OP_REMOVE_LONG;
      end else if (pick < 71) begin
        it.op = OP_GET_SHORT;
      end else if (pick < 88) begin
        it.op = OP_GET_LONG;
      end else if (pick < 91) begin
        it.op = OP_CLEAR;
      end else begin
        it.op = $urandom_range(0, 1) ? OP_RESERVED_A : OP_RESERVED_B;
      end
      ops_to_send.push_back(it);
    end
    if (long_hold) holds_asked++;
  endtask

  // reset, directed ops, then random phases under several register settings
  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // misses on an empty table
    queue_op(OP_GET_LONG, 16'h0000, 64'h0, 8'h00);
    queue_op(OP_REMOVE_LONG, 16'hffff, '1, 8'hff);
    // new slots, one given the keep value
    queue_op(OP_ADD, 16'h0000, 64'h0, CAP_KEEP);
    queue_op(OP_ADD, 16'hffff, '1, 8'hfe);
    queue_op(OP_GET_LONG, 16'h0000, 64'h1, 8'h00);
    queue_op(OP_GET_SHORT, 16'h0001, '1, 8'h00);
    // update through a short match keeping the capability, then a long match
    queue_op(OP_ADD, 16'h0000, 64'h5, CAP_KEEP);
    queue_op(OP_ADD, 16'h0007, '1, 8'h12);
    queue_op(OP_GET_LONG, 16'h0007, 64'h0, 8'h00);
    queue_op(OP_RESERVED_A, 16'h0000, 64'h5, 8'h00);
    queue_op(OP_RESERVED_B, 16'hffff, '1, 8'hff);
    // fill the table, then one add too many
    for (int i = 2; i < DKAM_ENTRIES; i++)
      queue_op(OP_ADD, SHORT_W'(16'h0100 + i), 64'h1000 + i, i[CAP_W-1:0]);
    queue_op(OP_ADD, 16'h1234, 64'hdead_beef_0000_0001, 8'h01);
    queue_op(OP_REMOVE_SHORT, 16'h0103, 64'h0, 8'h00);
    queue_op(OP_REMOVE_LONG, 16'h0000, 64'h1004, 8'h00);
    queue_op(OP_CLEAR, 16'h0000, 64'h0, 8'h00);
    queue_op(OP_GET_SHORT, 16'h0000, '1, 8'h00);
    run_phase(6, 200, 1'b0);
    wait_idle();

    write_reg(REG_INVALID_SHORT, '0);
    write_reg(REG_INVALID_LONG, '0);
    run_phase(28, 214, 1'b1);
    wait_idle();

    // extremes of the registers, and a stretch with no idling at all
    write_reg(REG_INVALID_SHORT, '1);
    write_reg(REG_INVALID_LONG, '1);
    write_reg(REG_SPARE_A, {$urandom, $urandom});
    calm = 1'b1;
    run_phase(20, 214, 1'b0);
    wait_idle();
    calm = 1'b0;

    write_reg(REG_INVALID_SHORT, {$urandom, $urandom});
    write_reg(REG_INVALID_LONG, {$urandom, $urandom});
    write_reg(REG_SPARE_B, {$urandom, $urandom});
    run_phase(10, 214, 1'b1);
    wait_idle();

    write_reg(REG_INVALID_LONG, {$urandom, $urandom});
    run_phase(28, 214, 1'b0);
    wait_idle();

    write_reg(REG_INVALID_SHORT, {$urandom, $urandom});
    run_phase(4, 214, 1'b0);
    wait_idle();
    repeat (10) @(negedge clk);

    $display("checked %0d results: %0d done or hit, %0d no match, %0d table full",
             results_checked, status_seen[STATUS_OK], status_seen[STATUS_MISS],
             status_seen[STATUS_FULL]);
    $display("%0d register writes, %0d long result hold-offs, %0d mismatches",
             reg_writes, holds_served, failures);
    if (failures == 0 && map_replies.size() == 0)
      $display("dual_key_address_map_unit regression: pass");
    else
      $display("dual_key_address_map_unit regression: fail");
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/dkam_pkg.sv
rtl/core/dkam_cfg.sv
rtl/core/dkam_table.sv
rtl/core/dual_key_address_map_unit.sv
tb/sv/testbench.sv
